### design/dmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_pkg: shared types and constants of the delimited message framer
// Holds the payload capacity, field widths, register indexes and the result
// word type passed from the framer core to the output register.
// ----------------------------------------------------------------------------
package dmf_pkg;

  // Payload capacity of one frame in bytes.
  localparam int MSG_CAP = 128;
  // Stored-byte counter must reach the capacity itself.
  localparam int CNT_W   = $clog2(MSG_CAP + 1);

  // Fixed field widths of the stream words.
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 7;
  localparam int LEN_W   = 8;
  localparam int PAT_W   = 32;
  localparam int OUT_DW  = 32;

  // Reset values of the delimiter registers ("qwer" and "abcd").
  localparam logic [PAT_W-1:0] START_PAT_RST = 32'h7177_6572;
  localparam logic [PAT_W-1:0] END_PAT_RST   = 32'h6162_6364;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_START_PAT = 1'b0,
    REG_END_PAT   = 1'b1
  } cfg_reg_t;

  // One result word.
  typedef struct packed {
    logic [BYTE_W-1:0] echo_byte;
    logic              stored;
    logic [IDX_W-1:0]  store_index;
    logic              frame_done;
    logic [LEN_W-1:0]  frame_length;
    logic              overflow;
  } dmf_result_t;

endpackage

### design/dmf_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_in_reg: input register of the framer
// Captures one received byte per cycle while the core consumes, holds it
// until consumed, and takes a new word in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module dmf_in_reg import dmf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              consume,
  output logic              hold_valid,
  output logic [BYTE_W-1:0] hold_byte
);

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;

  // Room exists when empty or when the held word leaves this cycle.
  assign in_tready = !valid_r || consume;
  assign valid_nxt = (in_tvalid && in_tready) || (valid_r && !consume);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

### design/dmf_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_core: start matcher, payload counter and end detector
// Holds the delimiter registers and the frame state, and computes the result
// word for the held byte in one pass of compare and shift logic.
// ----------------------------------------------------------------------------
module dmf_core import dmf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  cfg_reg_t          cfg_index,
  input  logic [PAT_W-1:0]  cfg_wdata,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  output dmf_result_t       result
);

  logic [PAT_W-1:0] start_pat_r;
  logic [PAT_W-1:0] end_pat_r;
  logic [1:0]       stage_r;
  logic [1:0]       stage_nxt;
  logic             rcv_r;
  logic             rcv_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [PAT_W-1:0] tail_r;
  logic [PAT_W-1:0] tail_nxt;

  logic [BYTE_W-1:0] exp_byte;
  logic              first_hit;
  logic              adv;
  logic              start_hit;
  logic              rcv_now;
  logic [CNT_W-1:0]  base_cnt;
  logic [CNT_W-1:0]  cnt_inc;
  logic [PAT_W-1:0]  tail_new;
  logic              done;
  logic              ovf;

  // Delimiter registers; an index that names no register changes nothing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pat_r <= START_PAT_RST;
      end_pat_r   <= END_PAT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_PAT: start_pat_r <= cfg_wdata;
        REG_END_PAT:   end_pat_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Expected start byte for the current stage, first byte in the top bits.
  always_comb begin
    unique case (stage_r)
      2'd0:    exp_byte = start_pat_r[31:24];
      2'd1:    exp_byte = start_pat_r[23:16];
      2'd2:    exp_byte = start_pat_r[15:8];
      default: exp_byte = start_pat_r[7:0];
    endcase
  end

  // While no frame is open, a byte equal to the first start byte restarts the
  // matcher, even when it would have completed the pattern.
  assign first_hit = (rx_byte == start_pat_r[31:24]);
  assign adv       = (stage_r != 2'd0) && (rx_byte == exp_byte);
  assign start_hit = !rcv_r && adv && (stage_r == 2'd3) && !first_hit;

  // Payload path: the completing start byte is stored as index zero.
  assign rcv_now  = rcv_r || start_hit;
  assign base_cnt = rcv_r ? cnt_r : '0;
  assign cnt_inc  = base_cnt + CNT_W'(1);
  assign tail_new = {(rcv_r ? tail_r[23:0] : 24'd0), rx_byte};
  assign done     = rcv_now && (cnt_inc >= CNT_W'(4)) && (tail_new == end_pat_r);
  assign ovf      = rcv_now && !done && (cnt_inc >= CNT_W'(MSG_CAP));

  // Next frame state.
  always_comb begin
    rcv_nxt  = rcv_now && !done && !ovf;
    cnt_nxt  = rcv_now ? cnt_inc : cnt_r;
    tail_nxt = rcv_now ? tail_new : tail_r;
    priority if (rcv_now) begin
      stage_nxt = 2'd0;
    end else if (first_hit) begin
      stage_nxt = 2'd1;
    end else if (adv) begin
      stage_nxt = stage_r + 2'd1;
    end else begin
      stage_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 2'd0;
      rcv_r   <= 1'b0;
      cnt_r   <= '0;
      tail_r  <= '0;
    end else if (step) begin
      stage_r <= stage_nxt;
      rcv_r   <= rcv_nxt;
      cnt_r   <= cnt_nxt;
      tail_r  <= tail_nxt;
    end
  end

  // Result word for the held byte.
  always_comb begin
    result.echo_byte    = rx_byte;
    result.stored       = rcv_now;
    result.store_index  = rcv_now ? IDX_W'(base_cnt) : '0;
    result.frame_done   = done;
    result.frame_length = done ? LEN_W'(cnt_inc) : '0;
    result.overflow     = ovf;
  end

endmodule

### design/dmf_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_out_reg: result register of the framer
// Holds one finished result word until the sink takes it, and reloads in the
// same cycle the held word is taken.
// ----------------------------------------------------------------------------
module dmf_out_reg import dmf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load_valid,
  output logic        load_ready,
  input  dmf_result_t load_word,
  output logic        out_tvalid,
  input  logic        out_tready,
  output dmf_result_t out_word
);

  logic        valid_r;
  logic        valid_nxt;
  dmf_result_t word_r;

  assign load_ready = !valid_r || out_tready;
  assign valid_nxt  = (load_valid && load_ready) || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      word_r <= load_word;
    end
  end

  assign out_tvalid = valid_r;
  assign out_word   = word_r;

endmodule

### design/delimited_message_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_message_framer: start/end delimited packet framer
// Echoes every received byte and marks the bytes that belong to a frame
// opened by the start delimiter and closed by the end delimiter.
// ----------------------------------------------------------------------------
//  Channel  Direction  Word / fields
//  in_      slave      tdata[7:0] rx_byte
//  out_     master     tdata: echo_byte, stored, store_index, frame_length,
//                      overflow; tlast: frame_done
//  cfg_     write      index 0 start pattern, index 1 end pattern
//
//  One byte per cycle is accepted while the sink takes results; each byte
//  passes the input register and then the result register.
//  Reset is synchronous and active low; it restores both delimiters and
//  returns the matcher to idle. A stalled sink holds the result word and
//  the input register fills behind it before in_tready drops.
// ----------------------------------------------------------------------------
module delimited_message_framer import dmf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] rx_byte
  output logic              out_tvalid,
  input  logic              out_tready,
  // [7:0] echo_byte, [8] stored, [15:9] store_index, [23:16] frame_length,
  // [24] overflow, [31:25] zero
  output logic [OUT_DW-1:0] out_tdata,
  output logic              out_tlast,  // frame_done
  input  logic              cfg_we,
  input  cfg_reg_t          cfg_index,
  input  logic [PAT_W-1:0]  cfg_wdata
);

  logic              hold_valid;
  logic [BYTE_W-1:0] hold_byte;
  logic              load_ready;
  logic              step;
  dmf_result_t       core_word;
  dmf_result_t       out_word;

  assign step = hold_valid && load_ready;

  dmf_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .consume    (load_ready),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  dmf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .rx_byte   (hold_byte),
    .result    (core_word)
  );

  dmf_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (hold_valid),
    .load_ready (load_ready),
    .load_word  (core_word),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_word   (out_word)
  );

  // Pack the result word onto the stream.
  assign out_tdata = {7'd0, out_word.overflow, out_word.frame_length,
                      out_word.store_index, out_word.stored, out_word.echo_byte};
  assign out_tlast = out_word.frame_done;

endmodule

### design/dmf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_checker: port-level checks of the framer
// Watches the result stream for stalls and for field combinations that the
// framing logic can never produce.
// ----------------------------------------------------------------------------
module dmf_checker import dmf_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic              out_tlast
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // A finished frame always ends on a stored byte with a length above three.
  a_done_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[8] && (out_tdata[23:16] >= 8'd4))
    else $error("frame done without a stored byte");

  // Overflow and frame done never come together, and overflow hits the last slot.
  a_ovf_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[24] |->
      !out_tlast && out_tdata[8] && (out_tdata[15:9] == IDX_W'(MSG_CAP - 1)))
    else $error("overflow reported at the wrong place");

  // Without a finished frame the length field is zero.
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[23:16] == 8'd0)
    else $error("frame length set without frame done");

endmodule

bind delimited_message_framer dmf_checker u_dmf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
